/* src/blea_pkg.sv */
package blea_pkg;

  localparam int AccWidth     = 48;
  localparam int CntWidth     = 32;
  localparam int AvgWidth     = 40;
  localparam int SmpWidth     = 32;
  localparam int CoefWidth    = 17;
  localparam int DivWidth     = AccWidth + 12;
  localparam int DivStepWidth = $clog2(DivWidth);
  localparam int ProdWidth    = AvgWidth + CoefWidth;

  localparam logic [SmpWidth-1:0]  TcReset = SmpWidth'(2000000);
  localparam logic [AccWidth-1:0]  AccMax  = {AccWidth{1'b1}};
  localparam logic [CntWidth-1:0]  CntMax  = {CntWidth{1'b1}};
  localparam logic [AvgWidth-1:0]  AvgMax  = {AvgWidth{1'b1}};
  localparam logic [CoefWidth-1:0] CoefOne = CoefWidth'(65536);

  typedef enum logic [1:0] {
    RegTimeConstant = 2'd0,
    RegBatchWindow  = 2'd1,
    RegStartAverage = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StEval,
    StDiv,
    StCoefA,
    StCoefB,
    StMulA,
    StMulB,
    StFold,
    StOut
  } ctrl_state_e;

  typedef struct packed {
    logic [SmpWidth-1:0] total_us;
    logic [SmpWidth-1:0] busy_us;
  } in_word_t;

  typedef struct packed {
    logic [AvgWidth-1:0] average;
    logic                folded;
  } out_word_t;

  typedef struct packed {
    logic cap_in;
    logic batch_add;
    logic div_start;
    logic coef_a;
    logic coef_b;
    logic mul_a;
    logic mul_b;
    logic fold_upd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fold_needed;
    logic div_done;
    logic out_busy;
  } ctrl_sts_t;

  // round(2^16 * exp(-k))
  function automatic logic [CoefWidth-1:0] exp_int_f(input logic [3:0] k);
    logic [CoefWidth-1:0] v;
    case (k)
      4'd0:    v = CoefWidth'(65536);
      4'd1:    v = CoefWidth'(24109);
      4'd2:    v = CoefWidth'(8869);
      4'd3:    v = CoefWidth'(3263);
      4'd4:    v = CoefWidth'(1200);
      4'd5:    v = CoefWidth'(442);
      4'd6:    v = CoefWidth'(162);
      4'd7:    v = CoefWidth'(60);
      4'd8:    v = CoefWidth'(22);
      4'd9:    v = CoefWidth'(8);
      4'd10:   v = CoefWidth'(3);
      4'd11:   v = CoefWidth'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round(2^16 * exp(-i/16))
  function automatic logic [CoefWidth-1:0] exp_frac_f(input logic [4:0] i);
    logic [CoefWidth-1:0] v;
    case (i)
      5'd0:    v = CoefWidth'(65536);
      5'd1:    v = CoefWidth'(61565);
      5'd2:    v = CoefWidth'(57835);
      5'd3:    v = CoefWidth'(54331);
      5'd4:    v = CoefWidth'(51039);
      5'd5:    v = CoefWidth'(47947);
      5'd6:    v = CoefWidth'(45042);
      5'd7:    v = CoefWidth'(42313);
      5'd8:    v = CoefWidth'(39750);
      5'd9:    v = CoefWidth'(37341);
      5'd10:   v = CoefWidth'(35079);
      5'd11:   v = CoefWidth'(32954);
      5'd12:   v = CoefWidth'(30957);
      5'd13:   v = CoefWidth'(29081);
      5'd14:   v = CoefWidth'(27319);
      5'd15:   v = CoefWidth'(25664);
      default: v = CoefWidth'(24109);
    endcase
    return v;
  endfunction

endpackage

/* src/blea_div.sv */
module blea_div
  import blea_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivWidth-1:0] dividend_i,
  input  logic [SmpWidth-1:0] divisor_i,
  output logic                done_o,
  output logic [DivWidth-1:0] quotient_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DivStepWidth-1:0] cnt_q, cnt_d;
  logic [SmpWidth-1:0]     rem_q, rem_d;
  logic [SmpWidth-1:0]     dvs_q, dvs_d;
  logic [DivWidth-1:0]     quo_q, quo_d;
  logic [SmpWidth:0]       trial;
  logic                    fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DivWidth-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivStepWidth'(DivWidth - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? SmpWidth'(trial - {1'b0, dvs_q}) : trial[SmpWidth-1:0];
      quo_d = {quo_q[DivWidth-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/blea_ctrl.sv */
module blea_ctrl
  import blea_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = StEval;
        end
      end
      StEval: begin
        if (sts_i.fold_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else begin
          cmd_o.batch_add = 1'b1;
          state_d         = StOut;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StCoefA;
        end
      end
      StCoefA: begin
        cmd_o.coef_a = 1'b1;
        state_d      = StCoefB;
      end
      StCoefB: begin
        cmd_o.coef_b = 1'b1;
        state_d      = StMulA;
      end
      StMulA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = StMulB;
      end
      StMulB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = StFold;
      end
      StFold: begin
        cmd_o.fold_upd = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_only_on_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> sts_i.fold_needed)
    else $error("divide started without a fold");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == StDiv)
    else $error("divide finished outside the divide state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("output word overwritten while stalled");
`endif

endmodule

/* src/blea_dp.sv */
module blea_dp
  import blea_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_word_t            in_word_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [AvgWidth-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_sts_t           sts_o
);

  logic [SmpWidth-1:0]  tc_q;
  logic [SmpWidth-1:0]  win_q;
  logic [AvgWidth-1:0]  avg_q;
  logic [AccWidth-1:0]  bt_q;
  logic [AccWidth-1:0]  bb_q;
  logic [CntWidth-1:0]  cnt_q;
  logic                 fold_q;
  logic                 out_valid_q;
  out_word_t            out_word_q;
  in_word_t             in_q;
  logic                 big_q;
  logic [CoefWidth-1:0] ef_q;
  logic [CoefWidth-1:0] coef_q;
  logic [ProdWidth-1:0] p1_q;
  logic [ProdWidth-1:0] p2_q;

  logic [AccWidth:0]    ts_full;
  logic [AccWidth:0]    bs_full;
  logic [AccWidth-1:0]  time_sat;
  logic [AccWidth-1:0]  busy_sat;
  logic [SmpWidth-1:0]  tc_eff;
  logic [SmpWidth+3:0]  tc16;
  logic                 big;
  logic                 rat_done;
  logic                 mean_done;
  logic [DivWidth-1:0]  rat_q;
  logic [DivWidth-1:0]  mean_q;
  logic [AvgWidth-1:0]  mean;
  logic [3:0]           r_int;
  logic [3:0]           r_idx;
  logic [7:0]           r_lo;
  logic [CoefWidth-1:0] f_hi;
  logic [CoefWidth-1:0] f_lo;
  logic [24:0]          interp;
  logic [2*CoefWidth-1:0] cprod;
  logic [AvgWidth-1:0]  mul_a;
  logic [CoefWidth-1:0] mul_b;
  logic [ProdWidth-1:0] prod;
  logic [ProdWidth:0]   fold_sum;

  // saturating batch sums
  assign ts_full  = {1'b0, bt_q} + (AccWidth+1)'(in_q.total_us);
  assign bs_full  = {1'b0, bb_q} + (AccWidth+1)'(in_q.busy_us);
  assign time_sat = ts_full[AccWidth] ? AccMax : ts_full[AccWidth-1:0];
  assign busy_sat = bs_full[AccWidth] ? AccMax : bs_full[AccWidth-1:0];

  assign tc_eff = (tc_q == '0) ? SmpWidth'(1) : tc_q;
  assign tc16   = {tc_eff, 4'b0000};
  assign big    = {4'b0000, bt_q} >= (AccWidth+4)'(tc16);

  assign sts_o.fold_needed = (time_sat > AccWidth'(win_q)) && (cnt_q != '0);
  assign sts_o.div_done    = rat_done && mean_done;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  blea_div u_rat_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({bt_q, 12'b0}),
    .divisor_i  (tc_eff),
    .done_o     (rat_done),
    .quotient_o (rat_q)
  );

  blea_div u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (DivWidth'({bb_q, 8'b0})),
    .divisor_i  (cnt_q),
    .done_o     (mean_done),
    .quotient_o (mean_q)
  );

  assign mean = (mean_q[DivWidth-1:AvgWidth] != '0) ? AvgMax : mean_q[AvgWidth-1:0];

  // decay coefficient from the Q.12 ratio
  assign r_int  = rat_q[15:12];
  assign r_idx  = rat_q[11:8];
  assign r_lo   = rat_q[7:0];
  assign f_hi   = exp_frac_f({1'b0, r_idx});
  assign f_lo   = exp_frac_f({1'b0, r_idx} + 5'd1);
  assign interp = 25'(f_hi - f_lo) * 25'(r_lo) + 25'd128;
  assign cprod  = (2*CoefWidth)'(exp_int_f(r_int)) * (2*CoefWidth)'(ef_q)
                + (2*CoefWidth)'(32768);

  // shared multiplier
  assign mul_a    = cmd_i.mul_b ? mean : avg_q;
  assign mul_b    = cmd_i.mul_b ? (CoefOne - coef_q) : coef_q;
  assign prod     = ProdWidth'(mul_a) * ProdWidth'(mul_b);
  assign fold_sum = {1'b0, p1_q} + {1'b0, p2_q} + (ProdWidth+1)'(32768);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q <= in_word_i;
    end
    if (cmd_i.div_start) begin
      big_q <= big;
    end
    if (cmd_i.coef_a) begin
      ef_q <= f_hi - interp[24:8];
    end
    if (cmd_i.coef_b) begin
      coef_q <= big_q ? '0 : cprod[CoefWidth+15:16];
    end
    if (cmd_i.mul_a) begin
      p1_q <= prod;
    end
    if (cmd_i.mul_b) begin
      p2_q <= prod;
    end
    if (cmd_i.out_load) begin
      out_word_q.average <= avg_q;
      out_word_q.folded  <= fold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q        <= TcReset;
      win_q       <= '0;
      avg_q       <= '0;
      bt_q        <= '0;
      bb_q        <= '0;
      cnt_q       <= '0;
      fold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTimeConstant: tc_q  <= cfg_data_i[SmpWidth-1:0];
          RegBatchWindow:  win_q <= cfg_data_i[SmpWidth-1:0];
          RegStartAverage: avg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.cap_in) begin
        fold_q <= 1'b0;
      end
      if (cmd_i.batch_add) begin
        bt_q  <= time_sat;
        bb_q  <= busy_sat;
        cnt_q <= (cnt_q == CntMax) ? CntMax : cnt_q + 1'b1;
      end
      if (cmd_i.fold_upd) begin
        avg_q  <= fold_sum[AvgWidth+15:16];
        bt_q   <= AccWidth'(in_q.total_us);
        bb_q   <= AccWidth'(in_q.busy_us);
        cnt_q  <= CntWidth'(1);
        fold_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_fold_restarts_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold_upd |=> (cnt_q == CntWidth'(1)) && fold_q)
    else $error("batch not restarted after fold");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.coef_b |=> coef_q <= CoefOne)
    else $error("decay coefficient above one");
`endif

endmodule

/* src/batched_exponential_load_average.sv */
// Batched exponential load average.
// Input channel (in_valid_i/in_ready_o, in_word_i) takes one loop sample per
// word: total and busy time in microseconds. Every accepted word yields one
// output word (out_valid_o/out_ready_i, out_word_o) carrying the Q32.8
// average after that sample and a flag set when the sample folded the batch.
// Configuration port (cfg_valid_i/cfg_ready_o) is always ready; index 0 is
// the time constant, 1 the batch window, 2 loads the average. Write it only
// while no sample is in flight.
// A sample that does not fold passes the evaluate and output states before
// its word is registered; one that folds also passes the divide, coefficient,
// multiply and fold states. The fold time is set by the two bit-serial
// dividers (ratio and batch mean, one quotient bit per cycle over 60 bits,
// run side by side) followed by the coefficient and multiply steps on one
// shared 40x17 multiplier. One sample is processed at a time: the next
// sample is accepted only once the block is back in idle.
// A finished word sits in the output register; the next sample is accepted
// meanwhile, and the block holds before writing its result until the
// receiver takes the waiting word.
// Reset clears the average and batch, sets the time constant to 2000000 us
// and the window to zero.
module batched_exponential_load_average
  import blea_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [AvgWidth-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  blea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blea_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
